FILE: hdl/gsp_pkg.sv
// shared types and constants for the gated sine pulse train core
`default_nettype none

package gsp_pkg;

    // configuration port
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 32;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_MODE          = 3'd0,
        CFG_PHASE_STEP    = 3'd1,
        CFG_GATE_PERIOD   = 3'd2,
        CFG_GATE_ON_LAST  = 3'd3,
        CFG_BUFFER_LENGTH = 3'd4
    } cfg_index_t;

    // mode register codes
    typedef enum logic [1:0] {
        MODE_SINE  = 2'd0,
        MODE_PULSE = 2'd1,
        MODE_GATED = 2'd2
    } mode_t;

    // register widths and reset values
    localparam int GATE_WIDTH = 16;
    localparam int LEN_WIDTH  = 16;
    localparam int STEP_WIDTH = 32;

    localparam logic [1:0]            MODE_RESET     = 2'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_RESET     = 32'd0;
    localparam logic [GATE_WIDTH-1:0] PERIOD_RESET   = 16'd1;
    localparam logic [GATE_WIDTH-1:0] ON_LAST_RESET  = 16'd0;
    localparam logic [LEN_WIDTH-1:0]  LENGTH_RESET   = 16'd1024;

    // what the back end has to produce for one sample
    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_FULL = 2'd1,
        KIND_SINE = 2'd2
    } kind_t;

    // per-beat control carried down the sine pipeline
    typedef struct packed {
        logic  neg;
        kind_t kind;
        logic  last;
    } pipe_meta_t;

    // decoupling queue depth (power of two)
    localparam int QUEUE_DEPTH = 4;

    // unsigned Q30 arithmetic for the sine polynomial
    localparam int        QW      = 31;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;
    localparam logic [30:0] COEF_A1 = 31'd1686629713;
    localparam logic [30:0] COEF_A3 = 31'd693598668;
    localparam logic [30:0] COEF_A5 = 31'd85569306;
    localparam logic [30:0] COEF_A7 = 31'd5026995;
    localparam logic [30:0] COEF_A9 = 31'd172272;

endpackage

`default_nettype wire

FILE: hdl/gsp_front.sv
// front end: configuration registers, sample counters and beat classification
`default_nettype none

module gsp_front
    import gsp_pkg::*;
#(
    parameter int PHASE_WIDTH = 32,
    parameter int INDEX_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                       accept,
    input  wire logic                       restart,
    output logic [PHASE_WIDTH-1:0]          item_phase,
    output kind_t                           item_kind,
    output logic                            item_last
);

    localparam int CW = (INDEX_WIDTH + 1 > LEN_WIDTH + 1) ? INDEX_WIDTH + 1 : LEN_WIDTH + 1;
    localparam int SUMW = (PHASE_WIDTH > STEP_WIDTH) ? PHASE_WIDTH : STEP_WIDTH;

    logic [1:0]             mode_reg;
    logic [STEP_WIDTH-1:0]  step_reg;
    logic [GATE_WIDTH-1:0]  period_reg;
    logic [GATE_WIDTH-1:0]  on_last_reg;
    logic [LEN_WIDTH-1:0]   length_reg;

    logic [INDEX_WIDTH-1:0] index_reg, index_next;
    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [GATE_WIDTH-1:0]  gpos_reg, gpos_next;

    logic [INDEX_WIDTH-1:0] index_cur;
    logic [PHASE_WIDTH-1:0] phase_cur;
    logic [GATE_WIDTH-1:0]  gpos_cur;
    logic [GATE_WIDTH-1:0]  period_eff;
    logic [LEN_WIDTH-1:0]   length_eff;
    logic [CW-1:0]          index_inc;
    logic [GATE_WIDTH:0]    gpos_inc;
    logic [SUMW-1:0]        phase_sum;
    logic                   gate_on;
    logic                   last;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            step_reg    <= STEP_RESET;
            period_reg  <= PERIOD_RESET;
            on_last_reg <= ON_LAST_RESET;
            length_reg  <= LENGTH_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:          mode_reg    <= cfg_data[1:0];
                CFG_PHASE_STEP:    step_reg    <= cfg_data[STEP_WIDTH-1:0];
                CFG_GATE_PERIOD:   period_reg  <= cfg_data[GATE_WIDTH-1:0];
                CFG_GATE_ON_LAST:  on_last_reg <= cfg_data[GATE_WIDTH-1:0];
                CFG_BUFFER_LENGTH: length_reg  <= cfg_data[LEN_WIDTH-1:0];
                default:           ;
            endcase
        end
    end

    // restart clears the counters for this beat
    assign index_cur = restart ? '0 : index_reg;
    assign phase_cur = restart ? '0 : phase_reg;
    assign gpos_cur  = restart ? '0 : gpos_reg;

    // zero period or length behaves as one
    assign period_eff = (period_reg == '0) ? GATE_WIDTH'(1) : period_reg;
    assign length_eff = (length_reg == '0) ? LEN_WIDTH'(1) : length_reg;

    // end of buffer and gate window
    assign index_inc = CW'(index_cur) + CW'(1);
    assign last      = index_inc >= CW'(length_eff);
    assign gate_on   = gpos_cur <= on_last_reg;

    // counter advance
    assign gpos_inc  = {1'b0, gpos_cur} + (GATE_WIDTH + 1)'(1);
    assign phase_sum = SUMW'(phase_cur) + SUMW'(step_reg);

    always_comb
    begin
        if (last)
        begin
            index_next = '0;
            phase_next = '0;
            gpos_next  = '0;
        end
        else
        begin
            index_next = index_inc[INDEX_WIDTH-1:0];
            phase_next = phase_sum[PHASE_WIDTH-1:0];
            gpos_next  = (gpos_inc >= {1'b0, period_eff}) ? '0 : gpos_inc[GATE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_reg <= '0;
            phase_reg <= '0;
            gpos_reg  <= '0;
        end
        else if (accept)
        begin
            index_reg <= index_next;
            phase_reg <= phase_next;
            gpos_reg  <= gpos_next;
        end
    end

    // classify the beat for the back end
    always_comb
    begin
        case (mode_reg)
            MODE_SINE:  item_kind = KIND_SINE;
            MODE_PULSE: item_kind = gate_on ? KIND_FULL : KIND_ZERO;
            MODE_GATED: item_kind = gate_on ? KIND_SINE : KIND_ZERO;
            default:    item_kind = KIND_ZERO;
        endcase
    end

    assign item_phase = phase_cur;
    assign item_last  = last;

endmodule

`default_nettype wire

FILE: hdl/gsp_queue.sv
// small first-in first-out queue between front and back end
`default_nettype none

module gsp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  not_empty,
    output logic                  full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [NW-1:0]    count_reg;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + NW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - NW'(1);
            end
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign full      = count_reg == NW'(DEPTH);

endmodule

`default_nettype wire

FILE: hdl/gsp_back.sv
// back end: pipelined fixed-point sine, gating select and output register
`default_nettype none

module gsp_back
    import gsp_pkg::*;
#(
    parameter int PHASE_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    q_not_empty,
    input  wire logic [PHASE_WIDTH-1:0]  q_phase,
    input  wire kind_t                   q_kind,
    input  wire logic                    q_last,
    output logic                         q_pop,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic signed [SAMPLE_WIDTH-1:0] sample,
    output logic                         end_of_buffer
);

    localparam int FB = PHASE_WIDTH - 2;
    localparam logic [31:0] ROUND = 32'(1) << (30 - SAMPLE_WIDTH);
    localparam int FULL_INT = (1 << (SAMPLE_WIDTH - 1)) - 1;
    localparam logic [SAMPLE_WIDTH:0] FULL_W = (SAMPLE_WIDTH + 1)'(FULL_INT);

    logic [29:0]    r30;
    logic [QW-1:0]  x_in;
    logic           en;

    logic           vld_reg  [1:7];
    pipe_meta_t     meta_reg [1:7];
    logic [QW-1:0]  x_reg    [1:6];
    logic [QW-1:0]  x2_reg   [2:5];
    logic [QW-1:0]  t_reg    [3:6];
    logic [QW-1:0]  s_reg;

    logic [2*QW-1:0] p_sq, p_a9, p_t7, p_t5, p_t3, p_s;

    logic [31:0]             rnd;
    logic [SAMPLE_WIDTH:0]   mag_w;
    logic [SAMPLE_WIDTH-1:0] mag;
    logic [SAMPLE_WIDTH-1:0] mag_signed;
    logic [SAMPLE_WIDTH-1:0] sample_sel;

    logic                          valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                          eob_reg;

    // align the phase fraction to unsigned Q30
    if (FB >= 30)
    begin : g_frac_trunc
        assign r30 = q_phase[FB-1:FB-30];
    end
    else
    begin : g_frac_shift
        assign r30 = {q_phase[FB-1:0], {(30 - FB){1'b0}}};
    end

    // mirror the fraction in the odd quadrants
    assign x_in = q_phase[PHASE_WIDTH-2] ? (Q30_ONE - {1'b0, r30}) : {1'b0, r30};

    // whole pipeline advances unless the output beat is held
    assign en    = !(valid_reg && out_stall);
    assign q_pop = en && q_not_empty;

    // at most one multiply per stage
    assign p_sq = (2*QW)'(x_reg[1])  * (2*QW)'(x_reg[1]);
    assign p_a9 = (2*QW)'(x2_reg[2]) * (2*QW)'(COEF_A9);
    assign p_t7 = (2*QW)'(x2_reg[3]) * (2*QW)'(t_reg[3]);
    assign p_t5 = (2*QW)'(x2_reg[4]) * (2*QW)'(t_reg[4]);
    assign p_t3 = (2*QW)'(x2_reg[5]) * (2*QW)'(t_reg[5]);
    assign p_s  = (2*QW)'(x_reg[6])  * (2*QW)'(t_reg[6]);

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 7; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[1] <= q_not_empty;
            for (int k = 2; k <= 7; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            valid_reg <= vld_reg[7];
        end
    end

    // stage payloads: square, then Horner steps, then final product
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[1]         <= x_in;
            meta_reg[1].neg  <= q_phase[PHASE_WIDTH-1];
            meta_reg[1].kind <= q_kind;
            meta_reg[1].last <= q_last;
            for (int k = 2; k <= 7; k++)
            begin
                meta_reg[k] <= meta_reg[k-1];
            end
            for (int k = 2; k <= 6; k++)
            begin
                x_reg[k] <= x_reg[k-1];
            end
            x2_reg[2] <= p_sq[60:30];
            for (int k = 3; k <= 5; k++)
            begin
                x2_reg[k] <= x2_reg[k-1];
            end
            t_reg[3] <= COEF_A7 - p_a9[60:30];
            t_reg[4] <= COEF_A5 - p_t7[60:30];
            t_reg[5] <= COEF_A3 - p_t5[60:30];
            t_reg[6] <= COEF_A1 - p_t3[60:30];
            s_reg    <= p_s[60:30];
        end
    end

    // round half up, saturate, apply sign
    assign rnd        = {1'b0, s_reg} + ROUND;
    assign mag_w      = rnd[31:31-SAMPLE_WIDTH];
    assign mag        = (mag_w > FULL_W) ? FULL_W[SAMPLE_WIDTH-1:0] : mag_w[SAMPLE_WIDTH-1:0];
    assign mag_signed = meta_reg[7].neg ? (SAMPLE_WIDTH'(0) - mag) : mag;

    // pick the sample source
    always_comb
    begin
        case (meta_reg[7].kind)
            KIND_SINE: sample_sel = mag_signed;
            KIND_FULL: sample_sel = FULL_W[SAMPLE_WIDTH-1:0];
            KIND_ZERO: sample_sel = '0;
            default:   sample_sel = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sample_reg <= sample_sel;
            eob_reg    <= meta_reg[7].last;
        end
    end

    assign out_valid     = valid_reg;
    assign sample        = sample_reg;
    assign end_of_buffer = eob_reg;

endmodule

`default_nettype wire

FILE: hdl/gated_sine_pulse_train_core.sv
// top level of the gated sine pulse train generator
//
//  channel  | direction | handshake              | beat contents
//  ---------+-----------+------------------------+----------------------------------
//  in       | to core   | in_valid / in_stall    | restart
//  out      | from core | out_valid / out_stall  | sample, end_of_buffer
//  cfg      | to core   | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one sample per clock sustained while out_stall is low; latency from input beat to output beat is
// set by the polynomial sine pipeline (at most one multiplier per stage)
// reset loads the register defaults, clears index, phase and gate counters, empties the queue
// out_stall freezes the sine pipeline and output register; a four-entry queue absorbs
// input beats, and in_stall rises only when that queue is full
// cfg_ready is always high
`default_nettype none

module gated_sine_pulse_train_core
    import gsp_pkg::*;
#(
    parameter int PHASE_WIDTH  = 32,
    parameter int SAMPLE_WIDTH = 16,
    parameter int INDEX_WIDTH  = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]    cfg_data,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         restart,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]    sample,
    output logic                              end_of_buffer
);

    localparam int KW = $bits(kind_t);
    localparam int QDW = PHASE_WIDTH + KW + 1;

    logic                   accept;
    logic [PHASE_WIDTH-1:0] item_phase;
    kind_t                  item_kind;
    logic                   item_last;
    logic [QDW-1:0]         q_push_data;
    logic [QDW-1:0]         q_pop_data;
    logic                   q_pop;
    logic                   q_not_empty;
    logic                   q_full;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign accept    = in_valid && !q_full;

    // front end
    gsp_front #(
        .PHASE_WIDTH (PHASE_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .accept     (accept),
        .restart    (restart),
        .item_phase (item_phase),
        .item_kind  (item_kind),
        .item_last  (item_last)
    );

    // decoupling queue
    assign q_push_data = {item_phase, item_kind, item_last};

    gsp_queue #(
        .WIDTH (QDW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    // back end
    gsp_back #(
        .PHASE_WIDTH  (PHASE_WIDTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_not_empty   (q_not_empty),
        .q_phase       (q_pop_data[QDW-1:KW+1]),
        .q_kind        (kind_t'(q_pop_data[KW:1])),
        .q_last        (q_pop_data[0]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .end_of_buffer (end_of_buffer)
    );

endmodule

`default_nettype wire

FILE: hdl/gsp_checker.sv
// port-level checks for the gated sine pulse train core, with bind
`default_nettype none

module gsp_checker #(
    parameter int SAMPLE_WIDTH = 16
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    cfg_ready,
    input wire logic                    in_valid,
    input wire logic                    in_stall,
    input wire logic                    out_valid,
    input wire logic                    out_stall,
    input wire logic [SAMPLE_WIDTH-1:0] sample,
    input wire logic                    end_of_buffer
);

    // a held output beat stays offered
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output beat dropped while stalled");

    // a held output beat keeps its contents
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(sample) && $stable(end_of_buffer))
        else $error("output beat changed while stalled");

    // the queue only fills behind a stalled output beat
    a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> $past(out_valid && out_stall))
        else $error("input stalled without a held output beat");

    // input stall only rises after an accepted input beat
    a_in_stall_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid && !in_stall) && cfg_ready)
        else $error("input stall rose without a new input beat");

endmodule

bind gated_sine_pulse_train_core gsp_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_gsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_ready     (cfg_ready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .sample        (sample),
    .end_of_buffer (end_of_buffer)
);

`default_nettype wire

FILE: tb/sv/gated_sine_pulse_train_checker.sv
// checker for the gated sine pulse train core: watches the channels, predicts and compares samples
`default_nettype none

module gated_sine_pulse_train_checker
    import gsp_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    input  wire logic                       cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    input  wire logic                       in_valid,
    input  wire logic                       in_stall,
    input  wire logic                       restart,
    input  wire logic                       out_valid,
    input  wire logic                       out_stall,
    input  wire logic signed [15:0]         sample,
    input  wire logic                       end_of_buffer,
    output int                              mismatches,
    output int                              outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    // taylor coefficients of sin(pi/2 x) in unsigned q30
    localparam logic [63:0] TAYLOR_A1 = 64'd1686629713;
    localparam logic [63:0] TAYLOR_A3 = 64'd693598668;
    localparam logic [63:0] TAYLOR_A5 = 64'd85569306;
    localparam logic [63:0] TAYLOR_A7 = 64'd5026995;
    localparam logic [63:0] TAYLOR_A9 = 64'd172272;
    localparam logic [63:0] Q30_UNITY = 64'd1073741824;
    localparam logic [63:0] FULL_SCALE = 64'd32767;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               end_of_buffer;
    } osc_beat_t;

    // shadow of the configuration registers
    logic [1:0]  mode_reg;
    logic [31:0] step_reg;
    logic [15:0] period_reg;
    logic [15:0] on_last_reg;
    logic [15:0] length_reg;

    // shadow of the oscillator state
    logic [15:0] index_cnt;
    logic [31:0] phase_acc;
    logic [15:0] gate_pos;

    osc_beat_t expected_samples[$];
    osc_beat_t want;
    int        fail_count = 0;

    // polynomial sine of a 32-bit phase, rounded to q1.15
    function automatic logic [15:0] sine_q15(input logic [31:0] ph);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] mag;
        x = ph[30] ? (Q30_UNITY - {34'd0, ph[29:0]}) : {34'd0, ph[29:0]};
        x2 = (x * x) >> 30;
        t = TAYLOR_A7 - ((x2 * TAYLOR_A9) >> 30);
        t = TAYLOR_A5 - ((x2 * t) >> 30);
        t = TAYLOR_A3 - ((x2 * t) >> 30);
        t = TAYLOR_A1 - ((x2 * t) >> 30);
        s = (x * t) >> 30;
        mag = (s + 64'd16384) >> 15;
        if (mag > FULL_SCALE)
            mag = FULL_SCALE;
        if (ph[31])
            mag = 64'd0 - mag;
        return mag[15:0];
    endfunction

    // one tick of the oscillator: sample for the current state, then advance
    function automatic osc_beat_t advance_oscillator(input logic restart_bit);
        osc_beat_t   b;
        logic        gate_on;
        logic [16:0] period;
        logic [16:0] len;
        if (restart_bit)
        begin
            index_cnt = '0;
            phase_acc = '0;
            gate_pos  = '0;
        end
        period  = (period_reg == 16'd0) ? 17'd1 : {1'b0, period_reg};
        len     = (length_reg == 16'd0) ? 17'd1 : {1'b0, length_reg};
        gate_on = gate_pos <= on_last_reg;
        case (mode_reg)
            MODE_SINE:  b.sample = sine_q15(phase_acc);
            MODE_PULSE: b.sample = gate_on ? FULL_SCALE[15:0] : 16'd0;
            MODE_GATED: b.sample = gate_on ? sine_q15(phase_acc) : 16'd0;
            default:    b.sample = 16'd0;
        endcase
        b.end_of_buffer = ({1'b0, index_cnt} + 17'd1) >= len;
        if (b.end_of_buffer)
        begin
            index_cnt = '0;
            phase_acc = '0;
            gate_pos  = '0;
        end
        else
        begin
            index_cnt = index_cnt + 16'd1;
            phase_acc = phase_acc + step_reg;
            if (({1'b0, gate_pos} + 17'd1) >= period)
                gate_pos = '0;
            else
                gate_pos = gate_pos + 16'd1;
        end
        return b;
    endfunction

    // watch all three channels at each edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    = MODE_RESET;
            step_reg    = STEP_RESET;
            period_reg  = PERIOD_RESET;
            on_last_reg = ON_LAST_RESET;
            length_reg  = LENGTH_RESET;
            index_cnt   = '0;
            phase_acc   = '0;
            gate_pos    = '0;
            expected_samples.delete();
            outstanding <= 0;
            mismatches  <= fail_count;
        end
        else
        begin
            // register write beat
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MODE:          mode_reg    = cfg_data[1:0];
                    CFG_PHASE_STEP:    step_reg    = cfg_data;
                    CFG_GATE_PERIOD:   period_reg  = cfg_data[15:0];
                    CFG_GATE_ON_LAST:  on_last_reg = cfg_data[15:0];
                    CFG_BUFFER_LENGTH: length_reg  = cfg_data[15:0];
                    default: ;
                endcase
            end
            // input beat: predict its sample
            if (in_valid && !in_stall)
                expected_samples.push_back(advance_oscillator(restart));
            // output beat: compare with the oldest prediction
            if (out_valid && !out_stall)
            begin
                if (expected_samples.size() == 0)
                begin
                    $error("unexpected output beat: sample %0d, end_of_buffer %0b",
                           sample, end_of_buffer);
                    fail_count++;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (sample !== want.sample)
                    begin
                        $error("sample: expected %0d, actual %0d", want.sample, sample);
                        fail_count++;
                    end
                    if (end_of_buffer !== want.end_of_buffer)
                    begin
                        $error("end_of_buffer: expected %0b, actual %0b",
                               want.end_of_buffer, end_of_buffer);
                        fail_count++;
                    end
                end
            end
            outstanding <= expected_samples.size();
            mismatches  <= fail_count;
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/gated_sine_pulse_train_core_tb.sv
// testbench top for the gated sine pulse train core: stimulus, register set-up and verdict
`default_nettype none

module gated_sine_pulse_train_core_tb
    import gsp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // the mode code that the core leaves unused
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 533;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_MODE;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       restart = 1'b0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [15:0]         sample;
    logic                       end_of_buffer;

    int mismatches;
    int outstanding;
    int idle_pct = 0;
    int stall_pct = 0;

    gated_sine_pulse_train_core #(
        .PHASE_WIDTH  (32),
        .SAMPLE_WIDTH (16),
        .INDEX_WIDTH  (16)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .end_of_buffer (end_of_buffer)
    );

    gated_sine_pulse_train_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sample        (sample),
        .end_of_buffer (end_of_buffer),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // one register write beat, held until cfg_ready, then cfg_valid drops
    task automatic write_register(input cfg_index_t idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // one tick beat, with random idle cycles in front
    task automatic send_tick(input logic restart_bit);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= restart_bit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // hold the sender until every predicted sample has come out
    task automatic drain_samples();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // random register set-up, extremes now and then, most writes taken
    task automatic random_setup();
        logic [1:0]  mode_v;
        logic [31:0] step_v;
        int          period_v;
        int          on_last_v;
        int          length_v;
        int          pick;
        pick = $urandom_range(0, 15);
        mode_v = (pick == 0) ? MODE_UNUSED : 2'(pick % 3);
        case ($urandom_range(0, 7))
            0:       step_v = 32'd0;
            1:       step_v = 32'hFFFF_FFFF;
            2:       step_v = 32'($urandom_range(1, 4096));
            default: step_v = $urandom();
        endcase
        case ($urandom_range(0, 9))
            0:       period_v = 0;
            1:       period_v = 65535;
            default: period_v = $urandom_range(1, 24);
        endcase
        case ($urandom_range(0, 7))
            0:       on_last_v = 0;
            1:       on_last_v = 65535;
            default: on_last_v = $urandom_range(0, (period_v > 65534) ? 65535 : period_v + 1);
        endcase
        case ($urandom_range(0, 9))
            0:       length_v = 0;
            1:       length_v = 65535;
            2:       length_v = 1;
            default: length_v = $urandom_range(2, 80);
        endcase
        // upper data bits are don't-care, so fill them at random
        if ($urandom_range(0, 4) != 0)
            write_register(CFG_MODE, ($urandom() & 32'hFFFF_FFFC) | {30'd0, mode_v});
        if ($urandom_range(0, 4) != 0)
            write_register(CFG_PHASE_STEP, step_v);
        if ($urandom_range(0, 4) != 0)
            write_register(CFG_GATE_PERIOD,
                           {16'($urandom_range(0, 65535)), 16'(period_v)});
        if ($urandom_range(0, 4) != 0)
            write_register(CFG_GATE_ON_LAST,
                           {16'($urandom_range(0, 65535)), 16'(on_last_v)});
        if ($urandom_range(0, 4) != 0)
            write_register(CFG_BUFFER_LENGTH,
                           {16'($urandom_range(0, 65535)), 16'(length_v)});
    endtask

    // stimulus and verdict
    initial
    begin
        int phase_no;
        int sent;
        int block_len;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults, both restart values
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        // quarter-turn steps hit every quadrant boundary
        write_register(CFG_MODE, {30'd0, MODE_SINE});
        write_register(CFG_PHASE_STEP, 32'h4000_0000);
        write_register(CFG_BUFFER_LENGTH, 32'd4);
        send_tick(1'b1);
        repeat (3) send_tick(1'b0);
        drain_samples();

        // gate period zero and buffer length zero
        write_register(CFG_MODE, {30'd0, MODE_PULSE});
        write_register(CFG_GATE_PERIOD, 32'd0);
        write_register(CFG_GATE_ON_LAST, 32'd0);
        write_register(CFG_BUFFER_LENGTH, 32'd0);
        repeat (2) send_tick(1'b0);
        drain_samples();

        // gated sine across two gate periods
        write_register(CFG_MODE, {30'd0, MODE_GATED});
        write_register(CFG_PHASE_STEP, 32'h1234_5678);
        write_register(CFG_GATE_PERIOD, 32'd4);
        write_register(CFG_GATE_ON_LAST, 32'd1);
        write_register(CFG_BUFFER_LENGTH, 32'd10);
        send_tick(1'b1);
        repeat (5) send_tick(1'b0);
        drain_samples();

        // shrink period and length below the running counters
        write_register(CFG_GATE_PERIOD, 32'd2);
        write_register(CFG_BUFFER_LENGTH, 32'd3);
        repeat (2) send_tick(1'b0);
        drain_samples();

        // unused mode and all-ones registers
        write_register(CFG_MODE, 32'hFFFF_FFFF);
        write_register(CFG_PHASE_STEP, 32'hFFFF_FFFF);
        write_register(CFG_GATE_PERIOD, 32'h0000_FFFF);
        write_register(CFG_GATE_ON_LAST, 32'h0000_FFFF);
        write_register(CFG_BUFFER_LENGTH, 32'h0000_FFFF);
        send_tick(1'b0);
        send_tick(1'b1);
        drain_samples();

        // random blocks under three idling regimes
        for (phase_no = 0; phase_no < 3; phase_no++)
        begin
            case (phase_no)
                0:
                begin
                    idle_pct  = 20;
                    stall_pct = 53;
                end
                1:
                begin
                    idle_pct  = 53;
                    stall_pct = 20;
                end
                default:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < ITEMS_PER_PHASE)
            begin
                random_setup();
                block_len = $urandom_range(40, 90);
                repeat (block_len) send_tick($urandom_range(0, 19) == 0);
                sent += block_len;
                drain_samples();
            end
        end

        // let any stray beat show up
        repeat (20) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

FILE: gated_sine_pulse_train_core.f
hdl/gsp_pkg.sv
hdl/gsp_front.sv
hdl/gsp_queue.sv
hdl/gsp_back.sv
hdl/gated_sine_pulse_train_core.sv
hdl/gsp_checker.sv
tb/sv/gated_sine_pulse_train_checker.sv
tb/sv/gated_sine_pulse_train_core_tb.sv
